[hdl/bouncing_point_trajectory_step_assert.svh]
// Assertion macros for the bouncing point trajectory step block.
// Depends on nothing; included by the top level only.
`ifndef BOUNCING_POINT_TRAJECTORY_STEP_ASSERT_SVH
`define BOUNCING_POINT_TRAJECTORY_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpt assertion failed (same cycle)");
// next-cycle implication
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpt assertion failed (next cycle)");
`else
`define BPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/bpt_pkg.sv]
// Shared types, constants and arithmetic helpers for the trajectory step block.
// No dependencies.
package bpt_pkg;

    localparam int COORD_W = 16;
    localparam int VEL_W   = COORD_W - 2;
    localparam int SUM_W   = COORD_W + 1;
    localparam int PROD_W  = COORD_W + 8;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;

    localparam logic signed [COORD_W-1:0] MIN_RESET = COORD_W'(0);
    localparam logic signed [COORD_W-1:0] MAX_RESET = COORD_W'(1023);

    // bounce coefficients: pos' = (37*wall - 17*pos)/20, vel' = -17*vel/20
    localparam logic signed [PROD_W-1:0] K_WALL = PROD_W'(37);
    localparam logic signed [PROD_W-1:0] K_DAMP = PROD_W'(17);

    // start velocity is (cur - prev)/8, truncated toward zero
    localparam int VEL_SHIFT = 3;
    localparam logic signed [SUM_W-1:0] START_ROUND = SUM_W'((1 << VEL_SHIFT) - 1);

    // divide by 20 = shift by 2, then multiply by ceil(2^K/5)
    localparam int DIV_SHIFT = PROD_W + 1;
    localparam logic [63:0] DIV_MULT_FULL = ((64'd1 << DIV_SHIFT) + 64'd4) / 64'd5;
    localparam logic [DIV_SHIFT-3:0] DIV_MULT = DIV_MULT_FULL[DIV_SHIFT-3:0];

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
    } wall_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos;
        logic signed [VEL_W-1:0]   vel;
    } axis_state_t;

    // signed divide by 20, truncating toward zero
    function automatic logic signed [PROD_W-1:0] div_by_20(input logic signed [PROD_W-1:0] a);
        logic [PROD_W-1:0]                mag;
        logic [PROD_W-3:0]                quarter;
        logic [PROD_W+DIV_SHIFT-5:0]      prod;
        logic signed [PROD_W-1:0]         q;
        mag     = a[PROD_W-1] ? PROD_W'(-a) : PROD_W'(a);
        quarter = mag[PROD_W-1:2];
        prod    = (PROD_W+DIV_SHIFT-4)'(quarter) * (PROD_W+DIV_SHIFT-4)'(DIV_MULT);
        q       = PROD_W'(prod[PROD_W+DIV_SHIFT-5:DIV_SHIFT]);
        return a[PROD_W-1] ? -q : q;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
        if (v > SAT_HI)
            return COORD_W'(SAT_HI);
        else if (v < SAT_LO)
            return COORD_W'(SAT_LO);
        else
            return COORD_W'(v);
    endfunction

    function automatic logic signed [VEL_W-1:0] start_vel(input logic signed [COORD_W-1:0] cur,
                                                         input logic signed [COORD_W-1:0] prev);
        logic signed [SUM_W-1:0] diff;
        logic signed [SUM_W-1:0] adj;
        diff = SUM_W'(cur) - SUM_W'(prev);
        adj  = diff[SUM_W-1] ? diff + START_ROUND : diff;
        return VEL_W'(adj >>> VEL_SHIFT);
    endfunction

    function automatic logic [VEL_W:0] vel_mag(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W:0] w;
        w = (VEL_W+1)'(v);
        return w[VEL_W] ? (VEL_W+1)'(-w) : (VEL_W+1)'(w);
    endfunction

endpackage

[hdl/bpt_axis.sv]
// One axis of a trajectory step: move, test against the walls, bounce.
// Depends on bpt_pkg.
module bpt_axis (
    input  bpt_pkg::axis_state_t cur,
    input  bpt_pkg::wall_t       walls,
    output bpt_pkg::axis_state_t nxt
);

    logic signed [bpt_pkg::SUM_W-1:0]   sum;
    logic signed [bpt_pkg::PROD_W-1:0]  sum_w;
    logic signed [bpt_pkg::PROD_W-1:0]  wall_w;
    logic signed [bpt_pkg::PROD_W-1:0]  pos_term;
    logic signed [bpt_pkg::PROD_W-1:0]  vel_term;
    logic                               below;
    logic                               above;

    assign sum      = bpt_pkg::SUM_W'(cur.pos) + bpt_pkg::SUM_W'(cur.vel);
    assign sum_w    = bpt_pkg::PROD_W'(sum);
    // lower wall wins when both are crossed
    assign below    = sum < bpt_pkg::SUM_W'(walls.lo);
    assign above    = !below && (sum > bpt_pkg::SUM_W'(walls.hi));
    assign wall_w   = below ? bpt_pkg::PROD_W'(walls.lo) : bpt_pkg::PROD_W'(walls.hi);
    assign pos_term = bpt_pkg::K_WALL * wall_w - bpt_pkg::K_DAMP * sum_w;
    assign vel_term = -(bpt_pkg::K_DAMP * bpt_pkg::PROD_W'(cur.vel));

    always_comb
    begin
        if (below || above)
        begin
            nxt.pos = bpt_pkg::sat_coord(bpt_pkg::div_by_20(pos_term));
            nxt.vel = bpt_pkg::VEL_W'(bpt_pkg::div_by_20(vel_term));
        end
        else
        begin
            nxt.pos = bpt_pkg::sat_coord(sum_w);
            nxt.vel = cur.vel;
        end
    end

endmodule

[hdl/bouncing_point_trajectory_step.sv]
// Bouncing point trajectory step: input word register, per-axis step logic,
// position/velocity state and output handshake. Depends on bpt_pkg, bpt_axis
// and bouncing_point_trajectory_step_assert.svh.
//
// Usage
//   Input channel (in_valid / in_stall): one word per item. kind = 0 starts a
//   track from (prev, cur): position <= cur, velocity <= (cur - prev)/8.
//   kind = 1 advances one step, bouncing inelastically off the box walls.
//   Output channel (out_valid / out_stall): one word per item, the point.
//   Config: APB-style, four 16-bit walls at 0x0, 0x4, 0x8, 0xC (min_x,
//   min_y, max_x, max_y). Write only while the block is idle.
// Timing
//   out_valid rises once a word has passed the input register, then the step
//   logic into the state/output registers. Unless the output stalls,
//   throughput is one word per cycle; the step is a few constant multiplies
//   and two reciprocal multiplies per axis (position and velocity).
// Reset
//   Walls go to 0 / 1023, position and velocity to zero, both channels empty.
// Stall
//   The result waits in the output register; the input register still takes
//   one more word, then in_stall rises until the output drains.
`include "bouncing_point_trajectory_step_assert.svh"

module bouncing_point_trajectory_step (
    input  logic                                clk,
    input  logic                                rst_n,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpt_pkg::PADDR_W-1:0]         paddr,
    input  logic [bpt_pkg::PDATA_W-1:0]         pwdata,
    output logic [bpt_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [bpt_pkg::COORD_W-1:0]  prev_x,
    input  logic signed [bpt_pkg::COORD_W-1:0]  prev_y,
    input  logic signed [bpt_pkg::COORD_W-1:0]  cur_x,
    input  logic signed [bpt_pkg::COORD_W-1:0]  cur_y,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bpt_pkg::COORD_W-1:0]  point_x,
    output logic signed [bpt_pkg::COORD_W-1:0]  point_y
);

    // wall registers
    logic signed [bpt_pkg::COORD_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic                               cfg_wr;
    bpt_pkg::cfg_reg_t                  cfg_sel;

    // input word register
    logic                               s1_valid_reg, s1_valid_next;
    logic                               s1_kind_reg;
    logic signed [bpt_pkg::COORD_W-1:0] s1_prev_x_reg, s1_prev_y_reg;
    logic signed [bpt_pkg::COORD_W-1:0] s1_cur_x_reg, s1_cur_y_reg;

    // track state; the position doubles as the output word
    bpt_pkg::axis_state_t               x_reg, y_reg, x_next, y_next;
    bpt_pkg::axis_state_t               x_step, y_step;
    bpt_pkg::wall_t                     x_walls, y_walls;
    logic                               out_valid_reg, out_valid_next;

    logic                               in_fire;
    logic                               out_free;
    logic                               s2_fire;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = bpt_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= bpt_pkg::MIN_RESET;
            min_y_reg <= bpt_pkg::MIN_RESET;
            max_x_reg <= bpt_pkg::MAX_RESET;
            max_y_reg <= bpt_pkg::MAX_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                bpt_pkg::REG_MIN_X: min_x_reg <= bpt_pkg::COORD_W'(pwdata);
                bpt_pkg::REG_MIN_Y: min_y_reg <= bpt_pkg::COORD_W'(pwdata);
                bpt_pkg::REG_MAX_X: max_x_reg <= bpt_pkg::COORD_W'(pwdata);
                bpt_pkg::REG_MAX_Y: max_y_reg <= bpt_pkg::COORD_W'(pwdata);
                default: ;
            endcase
        end
    end

    // read back sign-extended
    always_comb
    begin
        unique case (cfg_sel)
            bpt_pkg::REG_MIN_X: prdata = bpt_pkg::PDATA_W'(min_x_reg);
            bpt_pkg::REG_MIN_Y: prdata = bpt_pkg::PDATA_W'(min_y_reg);
            bpt_pkg::REG_MAX_X: prdata = bpt_pkg::PDATA_W'(max_x_reg);
            bpt_pkg::REG_MAX_Y: prdata = bpt_pkg::PDATA_W'(max_y_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // stall only when the input register is full and the output is blocked
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s2_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg   <= kind;
            s1_prev_x_reg <= prev_x;
            s1_prev_y_reg <= prev_y;
            s1_cur_x_reg  <= cur_x;
            s1_cur_y_reg  <= cur_y;
        end
    end

    // ---------------- step logic ----------------
    assign x_walls.lo = min_x_reg;
    assign x_walls.hi = max_x_reg;
    assign y_walls.lo = min_y_reg;
    assign y_walls.hi = max_y_reg;

    bpt_axis u_axis_x (
        .cur   (x_reg),
        .walls (x_walls),
        .nxt   (x_step)
    );

    bpt_axis u_axis_y (
        .cur   (y_reg),
        .walls (y_walls),
        .nxt   (y_step)
    );

    always_comb
    begin
        if (s1_kind_reg)
        begin
            x_next = x_step;
            y_next = y_step;
        end
        else
        begin
            x_next.pos = s1_cur_x_reg;
            x_next.vel = bpt_pkg::start_vel(s1_cur_x_reg, s1_prev_x_reg);
            y_next.pos = s1_cur_y_reg;
            y_next.vel = bpt_pkg::start_vel(s1_cur_y_reg, s1_prev_y_reg);
        end
    end

    // state is part of the track, so it resets to the origin at rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (s2_fire)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = x_reg.pos;
    assign point_y   = y_reg.pos;

    // ---------------- assertions ----------------
    // back-pressure only comes from a blocked output with a word waiting
    `BPT_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    // a waiting input word always reaches the output once it is free
    `BPT_ASSERT_NEXT(a_word_moves, clk, rst_n, s1_valid_reg && out_free, out_valid_reg)
    // a step never speeds the point up
    `BPT_ASSERT_NEXT(a_vel_decays_x, clk, rst_n, s2_fire && s1_kind_reg,
        bpt_pkg::vel_mag(x_reg.vel) <= $past(bpt_pkg::vel_mag(x_reg.vel)))
    `BPT_ASSERT_NEXT(a_vel_decays_y, clk, rst_n, s2_fire && s1_kind_reg,
        bpt_pkg::vel_mag(y_reg.vel) <= $past(bpt_pkg::vel_mag(y_reg.vel)))

endmodule

[verif/bouncing_point_trajectory_step_tb.sv]
// Self-checking testbench for bouncing_point_trajectory_step: directed table, then random
// tracks in several boxes and flow-control mixes, checked by a predictor or table points.
// Depends on bpt_pkg and the block's RTL only.
`timescale 1ns / 100ps

module bouncing_point_trajectory_step_tb;

    // kind field of an input word
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // bounce arithmetic: pos' = (37*wall - 17*pos)/20, vel' = -17*vel/20; launch vel = d/8
    localparam int WALL_GAIN = 37;
    localparam int DAMP_GAIN = 17;
    localparam int DAMP_DIV  = 20;
    localparam int VEL_DIV   = 8;

    localparam logic signed [bpt_pkg::COORD_W-1:0] C_LO =
        {1'b1, {(bpt_pkg::COORD_W-1){1'b0}}};
    localparam logic signed [bpt_pkg::COORD_W-1:0] C_HI =
        {1'b0, {(bpt_pkg::COORD_W-1){1'b1}}};

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = 135;
    localparam int HOLD_CYCLES   = 64;     // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES = 6;      // settle margin once the expected queue is empty
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 50;

    typedef enum logic [1:0] {
        FLOW_STEADY,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    // ROW_BOX rows carry the walls in the point fields: prev = (min_x, min_y),
    // cur = (max_x, max_y)
    typedef enum logic {
        ROW_WORD,
        ROW_BOX
    } row_op_t;

    typedef struct packed {
        logic signed [bpt_pkg::COORD_W-1:0] x;
        logic signed [bpt_pkg::COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        row_op_t                            op;
        logic                               kind;
        logic signed [bpt_pkg::COORD_W-1:0] px;
        logic signed [bpt_pkg::COORD_W-1:0] py;
        logic signed [bpt_pkg::COORD_W-1:0] cx;
        logic signed [bpt_pkg::COORD_W-1:0] cy;
        logic                               typed;   // expected point written out below
        logic signed [bpt_pkg::COORD_W-1:0] ex;
        logic signed [bpt_pkg::COORD_W-1:0] ey;
    } vec_row_t;

    localparam int NUM_VECTORS = 25;
    localparam vec_row_t VECTORS [NUM_VECTORS] = '{
        // step from reset state, then again with junk in the ignored fields
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, C_HI, C_LO, -16'sd1, 16'sd21845, 1'b1, 16'sd0, 16'sd0},
        // plain track inside the reset box
        '{ROW_WORD, KIND_START, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 1'b1, 16'sd100, 16'sd200},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // fastest positive launch: overshoots the top wall and saturates low
        '{ROW_WORD, KIND_START, C_LO, C_LO, C_HI, C_HI, 1'b1, C_HI, C_HI},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // fastest negative launch: under the bottom wall, saturates high
        '{ROW_WORD, KIND_START, C_HI, C_HI, C_LO, C_LO, 1'b1, C_LO, C_LO},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // velocity division truncates toward zero (+-7/8 -> 0, +-9/8 -> +-1)
        '{ROW_WORD, KIND_START, 16'sd7, -16'sd7, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_START, 16'sd9, -16'sd9, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // full-range box: pos + vel leaves 16 bits before the bounce
        '{ROW_BOX, KIND_STEP, C_LO, C_LO, C_HI, C_HI, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_START, 16'sd0, 16'sd0, C_HI, C_LO, 1'b1, C_HI, C_LO},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // min above max: lower wall rule must win
        '{ROW_BOX, KIND_STEP, 16'sd500, 16'sd400, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_START, 16'sd300, 16'sd300, 16'sd300, 16'sd300, 1'b1, 16'sd300, 16'sd300},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // back to the reset box, small negative velocity near the top wall
        '{ROW_BOX, KIND_STEP, 16'sd0, 16'sd0, 16'sd1023, 16'sd1023, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, KIND_START, -16'sd16, 16'sd1040, 16'sd0, 16'sd1023, 1'b1, 16'sd0, 16'sd1023},
        '{ROW_WORD, KIND_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [bpt_pkg::PADDR_W-1:0]        paddr;
    logic [bpt_pkg::PDATA_W-1:0]        pwdata;
    logic [bpt_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_stall;
    logic                               kind;
    logic signed [bpt_pkg::COORD_W-1:0] prev_x;
    logic signed [bpt_pkg::COORD_W-1:0] prev_y;
    logic signed [bpt_pkg::COORD_W-1:0] cur_x;
    logic signed [bpt_pkg::COORD_W-1:0] cur_y;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [bpt_pkg::COORD_W-1:0] point_x;
    logic signed [bpt_pkg::COORD_W-1:0] point_y;

    // predictor state: box walls and the tracked point, per axis
    bpt_pkg::wall_t       box_x;
    bpt_pkg::wall_t       box_y;
    bpt_pkg::axis_state_t track_x;
    bpt_pkg::axis_state_t track_y;

    point_t expected_points[$];
    int     mismatch_count = 0;

    // flow control knobs, percent per cycle
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;   // bumped by stimulus, served by the receiver
    int hold_served     = 0;
    int hold_left       = 0;

    bouncing_point_trajectory_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .prev_x    (prev_x),
        .prev_y    (prev_y),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // generous cap on the run time; hitting it reports a fail
    initial
    begin
        #4_000_000;
        $display("bouncing_point_trajectory_step regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [bpt_pkg::COORD_W-1:0] clamp_coord(input int v);
        if (v > int'(C_HI))
            return C_HI;
        if (v < int'(C_LO))
            return C_LO;
        return bpt_pkg::COORD_W'(v);
    endfunction

    // one axis of a step: move, bounce off whichever wall is crossed (lower first), saturate
    function automatic bpt_pkg::axis_state_t bounce_axis(input bpt_pkg::axis_state_t s,
                                                         input bpt_pkg::wall_t       w);
        int                   nxt;
        int                   vel;
        int                   lo;
        int                   hi;
        bpt_pkg::axis_state_t r;
        vel = int'($signed(s.vel));
        nxt = int'($signed(s.pos)) + vel;
        lo  = int'($signed(w.lo));
        hi  = int'($signed(w.hi));
        if (nxt < lo)
        begin
            nxt = (WALL_GAIN * lo - DAMP_GAIN * nxt) / DAMP_DIV;
            vel = (-DAMP_GAIN * vel) / DAMP_DIV;
        end
        else if (nxt > hi)
        begin
            nxt = (WALL_GAIN * hi - DAMP_GAIN * nxt) / DAMP_DIV;
            vel = (-DAMP_GAIN * vel) / DAMP_DIV;
        end
        r.pos = clamp_coord(nxt);
        r.vel = bpt_pkg::VEL_W'(vel);
        return r;
    endfunction

    function automatic bpt_pkg::axis_state_t launch_axis(
        input logic signed [bpt_pkg::COORD_W-1:0] prev,
        input logic signed [bpt_pkg::COORD_W-1:0] cur);
        bpt_pkg::axis_state_t r;
        r.pos = cur;
        r.vel = bpt_pkg::VEL_W'((int'(cur) - int'(prev)) / VEL_DIV);
        return r;
    endfunction

    // advances the tracked point by one accepted word and returns the point it emits
    function automatic point_t track_point(input logic k,
                                           input logic signed [bpt_pkg::COORD_W-1:0] px,
                                           input logic signed [bpt_pkg::COORD_W-1:0] py,
                                           input logic signed [bpt_pkg::COORD_W-1:0] cx,
                                           input logic signed [bpt_pkg::COORD_W-1:0] cy);
        point_t p;
        if (k == KIND_START)
        begin
            track_x = launch_axis(px, cx);
            track_y = launch_axis(py, cy);
        end
        else
        begin
            track_x = bounce_axis(track_x, box_x);
            track_y = bounce_axis(track_y, box_y);
        end
        p.x = track_x.pos;
        p.y = track_y.pos;
        return p;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // every accepted result word is matched to the oldest expected point
    always @(posedge clk)
    begin : check_results
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
                note_mismatch($sformatf("unexpected point (%0d, %0d)", point_x, point_y));
            else
            begin
                want = expected_points.pop_front();
                if (point_x !== want.x)
                    note_mismatch($sformatf("point_x got %0d want %0d", point_x, want.x));
                if (point_y !== want.y)
                    note_mismatch($sformatf("point_y got %0d want %0d", point_y, want.y));
            end
        end
    end

    // receiver: random stalls per phase, plus a long hold-off when stimulus asks
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // ---------------------------------------------------------------- stimulus

    task automatic set_flow(input flow_mode_t m);
        case (m)
            FLOW_STEADY:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SEND_GAPS:   begin send_idle_pct = 80; recv_stall_pct = 0;  end
            FLOW_RECV_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default:          begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    // present one word at the falling edge, hold it until accepted at a rising edge
    task automatic offer_word(input logic k,
                              input logic signed [bpt_pkg::COORD_W-1:0] px,
                              input logic signed [bpt_pkg::COORD_W-1:0] py,
                              input logic signed [bpt_pkg::COORD_W-1:0] cx,
                              input logic signed [bpt_pkg::COORD_W-1:0] cy);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        prev_x   <= px;
        prev_y   <= py;
        cur_x    <= cx;
        cur_y    <= cy;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic run_word(input logic k,
                            input logic signed [bpt_pkg::COORD_W-1:0] px,
                            input logic signed [bpt_pkg::COORD_W-1:0] py,
                            input logic signed [bpt_pkg::COORD_W-1:0] cx,
                            input logic signed [bpt_pkg::COORD_W-1:0] cy,
                            input logic typed,
                            input logic signed [bpt_pkg::COORD_W-1:0] ex,
                            input logic signed [bpt_pkg::COORD_W-1:0] ey);
        point_t p;
        offer_word(k, px, py, cx, cy);
        p = track_point(k, px, py, cx, cy);
        if (typed)
        begin
            p.x = ex;
            p.y = ey;
        end
        expected_points.push_back(p);
    endtask

    // drop valid, then wait for the pipe to empty and settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wall(input bpt_pkg::cfg_reg_t r,
                              input logic signed [bpt_pkg::COORD_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= bpt_pkg::PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            bpt_pkg::REG_MIN_X: box_x.lo = v;
            bpt_pkg::REG_MIN_Y: box_y.lo = v;
            bpt_pkg::REG_MAX_X: box_x.hi = v;
            default:            box_y.hi = v;
        endcase
    endtask

    task automatic load_box(input logic signed [bpt_pkg::COORD_W-1:0] lx,
                            input logic signed [bpt_pkg::COORD_W-1:0] ly,
                            input logic signed [bpt_pkg::COORD_W-1:0] hx,
                            input logic signed [bpt_pkg::COORD_W-1:0] hy);
        wait_drained();
        write_wall(bpt_pkg::REG_MIN_X, lx);
        write_wall(bpt_pkg::REG_MIN_Y, ly);
        write_wall(bpt_pkg::REG_MAX_X, hx);
        write_wall(bpt_pkg::REG_MAX_Y, hy);
    endtask

    // half the time in the box or up to 64 past a wall, else anywhere or at the extremes
    function automatic logic signed [bpt_pkg::COORD_W-1:0] pick_coord(input bpt_pkg::wall_t w);
        int lo;
        int hi;
        lo = ($signed(w.lo) < $signed(w.hi)) ? int'($signed(w.lo)) : int'($signed(w.hi));
        hi = ($signed(w.lo) < $signed(w.hi)) ? int'($signed(w.hi)) : int'($signed(w.lo));
        lo = int'(clamp_coord(lo - 64));
        hi = int'(clamp_coord(hi + 64));
        case ($urandom_range(3, 0))
            0:       return bpt_pkg::COORD_W'($urandom);
            1:       return $urandom_range(1, 0) ? C_HI : C_LO;
            default: return bpt_pkg::COORD_W'(lo + int'($urandom_range(hi - lo, 0)));
        endcase
    endfunction

    // earlier point mostly close by, so tracks bounce a few times before the next start
    function automatic logic signed [bpt_pkg::COORD_W-1:0] pick_prev(
        input logic signed [bpt_pkg::COORD_W-1:0] c);
        if ($urandom_range(3, 0) == 0)
            return bpt_pkg::COORD_W'($urandom);
        return clamp_coord(int'(c) + int'($urandom_range(800, 0)) - 400);
    endfunction

    initial
    begin : stimulus
        int                                 phase;
        int                                 n;
        vec_row_t                           row;
        logic                               k;
        logic signed [bpt_pkg::COORD_W-1:0] px;
        logic signed [bpt_pkg::COORD_W-1:0] py;
        logic signed [bpt_pkg::COORD_W-1:0] cx;
        logic signed [bpt_pkg::COORD_W-1:0] cy;
        logic signed [bpt_pkg::COORD_W-1:0] lx;
        logic signed [bpt_pkg::COORD_W-1:0] ly;
        logic signed [bpt_pkg::COORD_W-1:0] hx;
        logic signed [bpt_pkg::COORD_W-1:0] hy;
        logic signed [bpt_pkg::COORD_W-1:0] ra;
        logic signed [bpt_pkg::COORD_W-1:0] rb;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        kind      = KIND_START;
        prev_x    = '0;
        prev_y    = '0;
        cur_x     = '0;
        cur_y     = '0;

        box_x   = '{lo: bpt_pkg::MIN_RESET, hi: bpt_pkg::MAX_RESET};
        box_y   = '{lo: bpt_pkg::MIN_RESET, hi: bpt_pkg::MAX_RESET};
        track_x = '0;
        track_y = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, light gaps on both sides
        set_flow(FLOW_BOTH);
        for (n = 0; n < NUM_VECTORS; n++)
        begin
            row = VECTORS[n];
            if (row.op == ROW_BOX)
                load_box(row.px, row.py, row.cx, row.cy);
            else
                run_word(row.kind, row.px, row.py, row.cx, row.cy, row.typed, row.ex, row.ey);
        end

        // random tracks: each phase its own box and flow mix
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    lx = bpt_pkg::MIN_RESET;
                    ly = bpt_pkg::MIN_RESET;
                    hx = bpt_pkg::MAX_RESET;
                    hy = bpt_pkg::MAX_RESET;
                end
                1: begin lx = C_LO; ly = C_LO; hx = C_HI; hy = C_HI; end
                2: begin lx = -16'sd50; ly = -16'sd40; hx = 16'sd50; hy = 16'sd60; end
                3: begin lx = 16'sd200; ly = 16'sd300; hx = 16'sd100; hy = -16'sd100; end
                4:
                begin
                    ra = bpt_pkg::COORD_W'($urandom);
                    rb = bpt_pkg::COORD_W'($urandom);
                    lx = (ra < rb) ? ra : rb;
                    hx = (ra < rb) ? rb : ra;
                    ra = bpt_pkg::COORD_W'($urandom);
                    rb = bpt_pkg::COORD_W'($urandom);
                    ly = (ra < rb) ? ra : rb;
                    hy = (ra < rb) ? rb : ra;
                end
                5:
                begin
                    lx = bpt_pkg::COORD_W'($urandom);
                    ly = bpt_pkg::COORD_W'($urandom);
                    hx = bpt_pkg::COORD_W'($urandom);
                    hy = bpt_pkg::COORD_W'($urandom);
                end
                6: begin lx = C_LO; ly = C_LO; hx = -16'sd30000; hy = -16'sd31000; end
                default: begin lx = 16'sd30000; ly = 16'sd31000; hx = C_HI; hy = C_HI; end
            endcase
            load_box(lx, ly, hx, hy);
            set_flow(flow_mode_t'(phase % 4));

            for (n = 0; n < PHASE_WORDS; n++)
            begin
                // steady phase 4: long receiver hold while words keep coming,
                // later a full drain before going on
                if (phase == 4 && n == 20)
                    hold_requests++;
                if (phase == 4 && n == 90)
                    wait_drained();

                if ($urandom_range(99, 0) < 22)
                begin
                    k  = KIND_START;
                    cx = pick_coord(box_x);
                    cy = pick_coord(box_y);
                    px = pick_prev(cx);
                    py = pick_prev(cy);
                end
                else
                begin
                    // point fields are don't-care on a step; keep them noisy
                    k  = KIND_STEP;
                    px = bpt_pkg::COORD_W'($urandom);
                    py = bpt_pkg::COORD_W'($urandom);
                    cx = bpt_pkg::COORD_W'($urandom);
                    cy = bpt_pkg::COORD_W'($urandom);
                end
                run_word(k, px, py, cx, cy, 1'b0, '0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        n = 0;
        while (expected_points.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_points.size() != 0)
            note_mismatch($sformatf("%0d expected points never came out",
                                    expected_points.size()));

        if (mismatch_count == 0)
            $display("bouncing_point_trajectory_step regression: pass");
        else
            $display("bouncing_point_trajectory_step regression: fail");
        $finish;
    end

endmodule
